### hdl/mmfa_pkg.sv
// shared types and constants for the max-min fair block allocator
package mmfa_pkg;

    localparam int MAX_TENANTS = 32;
    localparam int DEMAND_BITS = 16;
    localparam int ID_W        = 5;
    localparam int IDX_W       = $clog2(MAX_TENANTS);
    localparam int CNT_W       = $clog2(MAX_TENANTS + 1);
    localparam int TOTAL_W     = 20;
    localparam int SUM_W       = DEMAND_BITS + IDX_W + 1;
    localparam int LEFT_W      = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
    localparam int ENTRY_W     = 2 * DEMAND_BITS;

    localparam logic [2:0] ACT_ADD      = 3'd0;
    localparam logic [2:0] ACT_REMOVE   = 3'd1;
    localparam logic [2:0] ACT_SET      = 3'd2;
    localparam logic [2:0] ACT_ALLOCATE = 3'd3;
    localparam logic [2:0] ACT_READ     = 3'd4;

    localparam logic [0:0] REG_TOTAL_BLOCKS = 1'd0;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  tenant_id;
        logic [15:0] demand;
    } mmfa_in_t;

    typedef struct packed {
        logic        status;
        logic        present;
        logic [15:0] tenant_demand;
        logic [15:0] tenant_allocation;
    } mmfa_out_t;

endpackage

### hdl/mmfa_ram.sv
// generic single-port ram with registered read
module mmfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hdl/mmfa_div.sv
// iterative restoring divider, one quotient bit per cycle
module mmfa_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mmfa_pkg::LEFT_W-1:0] dividend,
    input  logic [mmfa_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [mmfa_pkg::LEFT_W-1:0] quotient
);
    import mmfa_pkg::*;

    localparam int BIT_W = $clog2(LEFT_W + 1);

    logic [LEFT_W-1:0] quo_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic              run_reg;
    logic              done_reg;
    logic [CNT_W:0]    trial;

    assign trial    = {rem_reg[CNT_W-1:0], quo_reg[LEFT_W-1]};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && bit_reg == BIT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
            bit_reg <= BIT_W'(LEFT_W);
        end
        else if (run_reg)
        begin
            bit_reg <= bit_reg - BIT_W'(1);
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_reg <= trial - {1'b0, dsr_reg};
                quo_reg <= {quo_reg[LEFT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[LEFT_W-2:0], 1'b0};
            end
        end
    end
endmodule

### hdl/max_min_fair_block_allocator.sv
// top level of the max-min fair block allocator
//
// usage: pulse start with an item on in while busy is low; the block raises
// busy and, when the item is done, shows the result on out for one cycle with
// done high. results cannot be held off and need no acknowledge.
// table edits (add, remove, set demand) and reads pass through the ram read,
// modify and write back and result register, then the cycle that shows the
// result with busy already low.
// allocate with supply covering total demand runs one write pass (read, then
// write back, per tenant) before giving its result. otherwise each
// water-filling round costs a scan and a divide, the last scan and the write
// pass follow, and each leftover block costs a search and write; the number
// of rounds and of leftover blocks, at most MAX_TENANTS each, sets the time.
// total_blocks is to be written over the apb port only while the block is idle;
// the block itself does not enforce it. reads of paddr 0 return it.
// reset clears the control state and the present marks; tenant entries are
// kept in one ram of demand and allocation, cleared by a pass over every
// entry after reset during which busy stays high.
module max_min_fair_block_allocator
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mmfa_pkg::mmfa_in_t  in,
    output logic             done,
    output mmfa_pkg::mmfa_out_t out,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [1:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mmfa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_MOD, S_SCAN, S_DIV, S_FILL, S_EXTRA, S_DONE
    } state_t;

    state_t                 state_reg;
    logic [MAX_TENANTS-1:0] pres_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [TOTAL_W-1:0]     total_reg;
    mmfa_in_t               item_reg;
    mmfa_out_t              out_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [LEFT_W-1:0]      level_reg;
    logic [LEFT_W-1:0]      left_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [DEMAND_BITS-1:0] gap_reg;
    logic [MAX_TENANTS-1:0] given_reg;
    logic                   best_vld_reg;
    logic [IDX_W-1:0]       best_reg;
    logic [DEMAND_BITS-1:0] best_dem_reg;
    logic                   full_reg;

    logic                   we;
    logic [IDX_W-1:0]       addr;
    logic [ENTRY_W-1:0]     wdata;
    logic [ENTRY_W-1:0]     rdata;
    logic [DEMAND_BITS-1:0] rd_dem;
    logic [DEMAND_BITS-1:0] rd_alc;
    logic                   div_start;
    logic                   div_done;
    logic [LEFT_W-1:0]      div_q;
    logic [IDX_W-1:0]       cur_id;
    logic                   scan_last;
    logic                   above;
    logic [LEFT_W-1:0]      g_full;
    logic [LEFT_W-1:0]      step;
    logic [DEMAND_BITS-1:0] dem_in;
    logic [DEMAND_BITS-1:0] lvl_clip;

    assign rd_dem   = rdata[ENTRY_W-1:DEMAND_BITS];
    assign rd_alc   = rdata[DEMAND_BITS-1:0];
    assign cur_id   = item_reg.tenant_id[IDX_W-1:0];
    assign dem_in   = item_reg.demand[DEMAND_BITS-1:0];
    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign out      = out_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[1:0] == {REG_TOTAL_BLOCKS, 1'b0}) ? 32'(total_reg) : 32'd0;
    assign scan_last = (idx_reg == CNT_W'(MAX_TENANTS));
    assign above    = pres_reg[rd_idx_reg] && (LEFT_W'(rd_dem) > level_reg);
    assign g_full   = LEFT_W'(rd_dem) - level_reg;
    assign step     = (LEFT_W'(gap_reg) < div_q) ? LEFT_W'(gap_reg) : div_q;
    assign lvl_clip = DEMAND_BITS'(level_reg);

    mmfa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TENANTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    mmfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (left_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        we        = 1'b0;
        addr      = idx_reg[IDX_W-1:0];
        wdata     = '0;
        div_start = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
            end
            S_RD:
            begin
                addr = cur_id;
            end
            S_MOD:
            begin
                addr = cur_id;
                unique case (item_reg.action)
                    ACT_ADD:
                    begin
                        we = 1'b1;
                    end
                    ACT_REMOVE:
                    begin
                        we = pres_reg[cur_id];
                    end
                    ACT_SET:
                    begin
                        we    = 1'b1;
                        wdata = {dem_in, pres_reg[cur_id] ? rd_alc : DEMAND_BITS'(0)};
                    end
                    default:
                    begin
                        we = 1'b0;
                    end
                endcase
            end
            S_FILL:
            begin
                if (rd_vld_reg)
                begin
                    addr = rd_idx_reg;
                    we   = 1'b1;
                    if (!pres_reg[rd_idx_reg])
                    begin
                        wdata = '0;
                    end
                    else if (full_reg || LEFT_W'(rd_dem) < level_reg)
                    begin
                        wdata = {rd_dem, rd_dem};
                    end
                    else
                    begin
                        wdata = {rd_dem, lvl_clip};
                    end
                end
            end
            S_EXTRA:
            begin
                if (scan_last && rd_vld_reg)
                begin
                    addr = rd_idx_reg;
                end
                if (idx_reg == CNT_W'(MAX_TENANTS + 1))
                begin
                    addr  = best_reg;
                    we    = best_vld_reg;
                    wdata = {best_dem_reg, DEMAND_BITS'(level_reg + LEFT_W'(1))};
                end
            end
            S_DIV:
            begin
                div_start = (idx_reg == '0);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            pres_reg     <= '0;
            sum_reg      <= '0;
            total_reg    <= '0;
            done_reg     <= 1'b0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_idx_reg   <= '0;
            level_reg    <= '0;
            left_reg     <= '0;
            n_reg        <= '0;
            gap_reg      <= '0;
            given_reg    <= '0;
            best_vld_reg <= 1'b0;
            best_reg     <= '0;
            best_dem_reg <= '0;
            full_reg     <= 1'b0;
            item_reg     <= '0;
            out_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (psel && penable && pwrite && paddr == {REG_TOTAL_BLOCKS, 1'b0})
            begin
                total_reg <= pwdata[TOTAL_W-1:0];
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (idx_reg == CNT_W'(MAX_TENANTS - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg <= in;
                        if (in.action == ACT_ALLOCATE)
                        begin
                            level_reg  <= '0;
                            left_reg   <= LEFT_W'(total_reg);
                            full_reg   <= (LEFT_W'(total_reg) >= LEFT_W'(sum_reg));
                            given_reg  <= '0;
                            idx_reg    <= '0;
                            rd_vld_reg <= 1'b0;
                            n_reg      <= '0;
                            gap_reg    <= '0;
                            if (LEFT_W'(total_reg) >= LEFT_W'(sum_reg))
                            begin
                                state_reg <= S_FILL;
                            end
                            else
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (!scan_last)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    rd_vld_reg <= !scan_last;
                    rd_idx_reg <= idx_reg[IDX_W-1:0];
                    if (rd_vld_reg && above)
                    begin
                        n_reg <= n_reg + CNT_W'(1);
                        if (n_reg == '0 || DEMAND_BITS'(g_full) < gap_reg)
                        begin
                            gap_reg <= DEMAND_BITS'(g_full);
                        end
                    end
                    if (scan_last && !rd_vld_reg)
                    begin
                        idx_reg <= '0;
                        if (n_reg == '0 || left_reg < LEFT_W'(n_reg))
                        begin
                            state_reg <= S_FILL;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    idx_reg <= CNT_W'(1);
                    if (div_done)
                    begin
                        level_reg <= level_reg + step;
                        left_reg  <= left_reg - LEFT_W'(n_reg) * step;
                        n_reg     <= '0;
                        gap_reg   <= '0;
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_FILL:
                begin
                    // read one entry, write it back the next cycle
                    if (rd_vld_reg)
                    begin
                        rd_vld_reg <= 1'b0;
                    end
                    else if (!scan_last)
                    begin
                        idx_reg    <= idx_reg + CNT_W'(1);
                        rd_vld_reg <= 1'b1;
                        rd_idx_reg <= idx_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        idx_reg      <= '0;
                        best_vld_reg <= 1'b0;
                        if (full_reg || left_reg == '0)
                        begin
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            state_reg <= S_EXTRA;
                        end
                    end
                end
                S_EXTRA:
                begin
                    if (idx_reg == CNT_W'(MAX_TENANTS + 1))
                    begin
                        idx_reg      <= '0;
                        rd_vld_reg   <= 1'b0;
                        best_vld_reg <= 1'b0;
                        if (best_vld_reg)
                        begin
                            given_reg[best_reg] <= 1'b1;
                            left_reg <= left_reg - LEFT_W'(1);
                        end
                        if (!best_vld_reg || left_reg == LEFT_W'(1))
                        begin
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        if (!scan_last)
                        begin
                            idx_reg <= idx_reg + CNT_W'(1);
                        end
                        else if (!rd_vld_reg)
                        begin
                            idx_reg <= CNT_W'(MAX_TENANTS + 1);
                        end
                        rd_vld_reg <= !scan_last;
                        rd_idx_reg <= idx_reg[IDX_W-1:0];
                        if (rd_vld_reg && above && !given_reg[rd_idx_reg]
                            && (!best_vld_reg || rd_dem < best_dem_reg))
                        begin
                            best_vld_reg <= 1'b1;
                            best_reg     <= rd_idx_reg;
                            best_dem_reg <= rd_dem;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    state_reg <= S_DONE;
                    out_reg.status <= 1'b0;
                    out_reg.present <= pres_reg[cur_id];
                    out_reg.tenant_demand <= pres_reg[cur_id] ? rd_dem : '0;
                    out_reg.tenant_allocation <= pres_reg[cur_id] ? rd_alc : '0;
                    unique case (item_reg.action)
                        ACT_ADD:
                        begin
                            if (pres_reg[cur_id])
                            begin
                                sum_reg <= sum_reg - SUM_W'(rd_dem);
                            end
                            pres_reg[cur_id] <= 1'b1;
                            out_reg.present <= 1'b1;
                            out_reg.tenant_demand <= '0;
                            out_reg.tenant_allocation <= '0;
                        end
                        ACT_REMOVE:
                        begin
                            if (pres_reg[cur_id])
                            begin
                                sum_reg <= sum_reg - SUM_W'(rd_dem);
                                pres_reg[cur_id] <= 1'b0;
                                out_reg.present <= 1'b0;
                                out_reg.tenant_demand <= '0;
                                out_reg.tenant_allocation <= '0;
                            end
                            else
                            begin
                                out_reg.status <= 1'b1;
                            end
                        end
                        ACT_SET:
                        begin
                            sum_reg <= sum_reg + SUM_W'(dem_in)
                                - (pres_reg[cur_id] ? SUM_W'(rd_dem) : SUM_W'(0));
                            pres_reg[cur_id] <= 1'b1;
                            out_reg.present <= 1'b1;
                            out_reg.tenant_demand <= dem_in;
                            out_reg.tenant_allocation <=
                                pres_reg[cur_id] ? rd_alc : '0;
                        end
                        ACT_READ:
                        begin
                            out_reg.status <= !pres_reg[cur_id];
                        end
                        default:
                        begin
                            out_reg.status <= 1'b0;
                        end
                    endcase
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

### hdl/mmfa_checker.sv
// port-level checker for the allocator, bound to the top level
module mmfa_checker
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input mmfa_pkg::mmfa_out_t out,
    input logic      pready
);
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item accepted without busy");

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while result shown");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !out.present |-> out.tenant_demand == '0 && out.tenant_allocation == '0)
        else $error("absent tenant with nonzero fields");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind max_min_fair_block_allocator mmfa_checker u_mmfa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .out    (out),
    .pready (pready)
);
